// File: hdl/aenc_pkg.sv
// Shared types and constants for the 32-bit arithmetic encoder.
`default_nettype none
package aenc_pkg;
	localparam int FreqBits = 16;
	localparam int PendBits = 8;
	localparam logic [31:0] Half = 32'h8000_0000;
	localparam logic [31:0] Quarter = 32'h4000_0000;
	localparam logic [31:0] ThreeQ = 32'hC000_0000;
	localparam logic [PendBits-1:0] PendLimit = '1;

	typedef enum logic {
		CMD_ENCODE = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_APPLY,
		ST_RENORM,
		ST_BIT,
		ST_PEND,
		ST_FIN_BUMP,
		ST_FIN_BIT,
		ST_FIN_PEND,
		ST_FIN_PAD,
		ST_FLUSH,
		ST_BAD
	} state_t;

	typedef enum logic [1:0] {
		REN_ZERO,
		REN_ONE,
		REN_MID,
		REN_DONE
	} ren_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic apply;
		logic shift_zero;
		logic shift_one;
		logic shift_mid;
		logic bump;
		logic put_bit;
		logic put_pend;
		logic pad;
		logic clear_all;
		logic out_take;
		logic out_rel;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic cmd_finish;
		ren_t ren;
		logic div_done;
		logic pend_zero;
		logic bits_zero;
		logic byte_full;
		logic out_full;
		logic out_fire;
		logic any_byte;
	} sts_t;
endpackage
`default_nettype wire

// File: hdl/arithmetic_encoder_32bit.sv
// Top level of the 32-bit binary arithmetic encoder.
// Encode: narrowing loads the item, runs a serial divide and applies the new bounds; then
// each renormalization shift follows, a 0/1 shift also emitting its bit and any pending bits.
// One item at a time: the next input is taken only once the current encode, rejected item or
// finish has completed; output back-pressure adds stalls.
// Reset (arst_n low) clears the interval to [0, 0xFFFFFFFF] and all counters.
`default_nettype none
module arithmetic_encoder_32bit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic i_valid,
	output logic i_ready,
	input wire logic command,
	input wire logic [15:0] cum_low,
	input wire logic [15:0] cum_high,
	input wire logic [15:0] total,
	output logic o_valid,
	input wire logic o_ready,
	output logic [7:0] out_byte,
	output logic byte_valid,
	output logic bad_input,
	output logic pending_overflow,
	output logic last
);
	import aenc_pkg::*;

	ctl_t ctl;
	sts_t sts;

	aenc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .i_valid(i_valid), .i_ready(i_ready),
		.sts(sts), .ctl(ctl)
	);

	aenc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .command(command), .cum_low(cum_low),
		.cum_high(cum_high), .total(total), .ctl(ctl), .sts(sts),
		.o_ready(o_ready), .o_valid(o_valid), .out_byte(out_byte),
		.byte_valid(byte_valid), .bad_input(bad_input),
		.pending_overflow(pending_overflow), .last(last)
	);
endmodule
`default_nettype wire

// File: hdl/aenc_datapath.sv
// Datapath: interval registers, serial divider, bit packer and output register.
`default_nettype none
module aenc_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic command,
	input wire logic [15:0] cum_low,
	input wire logic [15:0] cum_high,
	input wire logic [15:0] total,
	input wire aenc_pkg::ctl_t ctl,
	output aenc_pkg::sts_t sts,
	input wire logic o_ready,
	output logic o_valid,
	output logic [7:0] out_byte,
	output logic byte_valid,
	output logic bad_input,
	output logic pending_overflow,
	output logic last
);
	import aenc_pkg::*;

	logic [31:0] low_q, high_q;
	logic [PendBits-1:0] pend_q;
	logic [7:0] pbyte_q;
	logic [2:0] pbits_q;
	logic ovf_q;
	logic cmd_q, bad_q, bit_q, any_q;
	logic [FreqBits-1:0] clo_q, chi_q, tot_q;
	logic [32:0] range_q;
	logic [48:0] qhi_q, qlo_q;
	logic [16:0] rhi_q, rlo_q;
	logic [5:0] dcnt_q;
	logic [7:0] obyte_q;
	logic obv_q, obad_q, oflag_q, olast_q, ofull_q, orel_q;

	logic [FreqBits-1:0] clo_in, chi_in, tot_in;
	logic bad_in;
	logic [16:0] rhi_sh, rlo_sh;
	logic [7:0] pbyte_nx;
	logic [31:0] up_v, dn_v;
	logic byte_wr;

	assign clo_in = cum_low[FreqBits-1:0];
	assign chi_in = cum_high[FreqBits-1:0];
	assign tot_in = total[FreqBits-1:0];
	assign bad_in = (tot_in == '0) || (clo_in >= chi_in) || (chi_in > tot_in);
	assign rhi_sh = {rhi_q[15:0], qhi_q[48]};
	assign rlo_sh = {rlo_q[15:0], qlo_q[48]};
	assign pbyte_nx = {pbyte_q[6:0], bit_q ^ ctl.put_pend};
	assign up_v = qhi_q[31:0] - 32'd1;
	assign dn_v = qlo_q[31:0];
	assign byte_wr = (ctl.put_bit || ctl.put_pend) && (pbits_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			high_q <= '1;
			pend_q <= '0;
			pbyte_q <= '0;
			pbits_q <= '0;
			ovf_q <= 1'b0;
			ofull_q <= 1'b0;
			orel_q <= 1'b0;
			obyte_q <= '0;
			obv_q <= 1'b0;
			obad_q <= 1'b0;
			oflag_q <= 1'b0;
			olast_q <= 1'b0;
			dcnt_q <= '0;
			any_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				any_q <= 1'b0;
			end
			if (ctl.div_start) begin
				dcnt_q <= 6'd49;
			end else if (ctl.div_step) begin
				dcnt_q <= dcnt_q - 6'd1;
			end
			if (ctl.apply) begin
				high_q <= low_q + up_v;
				low_q <= low_q + dn_v;
			end
			if (ctl.shift_zero) begin
				low_q <= {low_q[30:0], 1'b0};
				high_q <= {high_q[30:0], 1'b1};
			end
			if (ctl.shift_one) begin
				low_q <= {low_q[30:0] & 31'h7FFF_FFFF, 1'b0};
				high_q <= {high_q[30:0], 1'b1};
			end
			if (ctl.shift_mid) begin
				low_q <= {(low_q[30:0] - Quarter[30:0]), 1'b0};
				high_q <= {(high_q[30:0] - Quarter[30:0]), 1'b1};
			end
			if (ctl.bump) begin
				if (pend_q == PendLimit) begin
					ovf_q <= 1'b1;
				end else begin
					pend_q <= pend_q + 1'b1;
				end
			end
			if (ctl.put_pend) begin
				pend_q <= pend_q - 1'b1;
			end
			if (ctl.put_bit || ctl.put_pend) begin
				pbyte_q <= pbyte_nx;
				pbits_q <= pbits_q + 3'd1;
			end
			// a completed byte stays held until the next one or the item's end
			if (byte_wr) begin
				obyte_q <= pbyte_nx;
				obv_q <= 1'b1;
				obad_q <= 1'b0;
				oflag_q <= ovf_q || (ctl.bump && pend_q == PendLimit);
				olast_q <= 1'b0;
				ofull_q <= 1'b1;
				orel_q <= 1'b0;
				any_q <= 1'b1;
			end else if (ctl.pad) begin
				obyte_q <= pbyte_q << (4'd8 - {1'b0, pbits_q});
				obv_q <= 1'b1;
				obad_q <= 1'b0;
				oflag_q <= ovf_q;
				olast_q <= 1'b0;
				ofull_q <= 1'b1;
				orel_q <= 1'b0;
				any_q <= 1'b1;
			end else if (ctl.out_take) begin
				// closing transaction: an empty marker, or "last" on the held byte
				if (any_q) begin
					olast_q <= 1'b1;
					orel_q <= 1'b1;
				end else begin
					obyte_q <= '0;
					obv_q <= 1'b0;
					obad_q <= bad_q;
					oflag_q <= ovf_q;
					olast_q <= 1'b1;
					ofull_q <= 1'b1;
					orel_q <= 1'b1;
				end
			end else if (o_valid && o_ready) begin
				ofull_q <= 1'b0;
				orel_q <= 1'b0;
			end else if (ctl.out_rel) begin
				orel_q <= 1'b1;
			end
			if (ctl.clear_all) begin
				low_q <= '0;
				high_q <= '1;
				pend_q <= '0;
				pbyte_q <= '0;
				pbits_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// payload registers without reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			bad_q <= (command == CMD_ENCODE) && bad_in;
			clo_q <= clo_in;
			chi_q <= chi_in;
			tot_q <= tot_in;
			range_q <= {1'b0, high_q - low_q} + 33'd1;
		end
		if (ctl.div_start) begin
			qhi_q <= range_q * chi_q;
			qlo_q <= range_q * clo_q;
			rhi_q <= '0;
			rlo_q <= '0;
		end else if (ctl.div_step) begin
			if (rhi_sh >= {1'b0, tot_q}) begin
				rhi_q <= rhi_sh - {1'b0, tot_q};
				qhi_q <= {qhi_q[47:0], 1'b1};
			end else begin
				rhi_q <= rhi_sh;
				qhi_q <= {qhi_q[47:0], 1'b0};
			end
			if (rlo_sh >= {1'b0, tot_q}) begin
				rlo_q <= rlo_sh - {1'b0, tot_q};
				qlo_q <= {qlo_q[47:0], 1'b1};
			end else begin
				rlo_q <= rlo_sh;
				qlo_q <= {qlo_q[47:0], 1'b0};
			end
		end
		if (ctl.shift_zero) begin
			bit_q <= 1'b0;
		end
		if (ctl.shift_one) begin
			bit_q <= 1'b1;
		end
		if (ctl.bump && cmd_q == CMD_FINISH) begin
			bit_q <= (low_q >= Quarter);
		end
	end

	always_comb begin
		sts.bad = bad_q;
		sts.cmd_finish = cmd_q;
		if (high_q < Half) begin
			sts.ren = REN_ZERO;
		end else if (low_q >= Half) begin
			sts.ren = REN_ONE;
		end else if (low_q >= Quarter && high_q < ThreeQ) begin
			sts.ren = REN_MID;
		end else begin
			sts.ren = REN_DONE;
		end
		sts.div_done = (dcnt_q == 6'd0);
		sts.pend_zero = (pend_q == '0);
		sts.bits_zero = (pbits_q == 3'd0);
		sts.byte_full = (pbits_q == 3'd7);
		sts.out_full = ofull_q;
		sts.out_fire = o_valid && o_ready;
		sts.any_byte = any_q;
	end

	assign o_valid = ofull_q && orel_q;
	assign out_byte = obyte_q;
	assign byte_valid = obv_q;
	assign bad_input = obad_q;
	assign pending_overflow = oflag_q;
	assign last = olast_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.apply |=> (low_q <= high_q))
		else $error("interval inverted after narrowing");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ofull_q && !(o_valid && o_ready)) |-> !(byte_wr || ctl.pad))
		else $error("output register overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear_all |=> (low_q == '0 && high_q == '1 && pend_q == '0))
		else $error("finish did not restore reset state");
endmodule
`default_nettype wire

// File: hdl/aenc_ctrl.sv
// Controller state machine sequencing narrowing, renormalization and byte output.
`default_nettype none
module aenc_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic i_valid,
	output logic i_ready,
	input wire aenc_pkg::sts_t sts,
	output aenc_pkg::ctl_t ctl
);
	import aenc_pkg::*;

	state_t state_q, state_nx;
	logic room;
	logic wr_ok;

	// output register free this cycle or draining now
	assign room = !sts.out_full || sts.out_fire;
	// only a bit that completes a byte needs the output register
	assign wr_ok = !sts.byte_full || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (i_valid) state_nx = ST_MUL;
			ST_MUL: begin
				if (sts.cmd_finish) state_nx = ST_FIN_BUMP;
				else if (sts.bad) state_nx = ST_FLUSH;
				else state_nx = ST_DIV;
			end
			ST_DIV: if (sts.div_done) state_nx = ST_APPLY;
			ST_APPLY: state_nx = ST_RENORM;
			ST_RENORM: begin
				unique case (sts.ren)
					REN_ZERO, REN_ONE: state_nx = ST_BIT;
					REN_MID: state_nx = ST_RENORM;
					REN_DONE: state_nx = ST_FLUSH;
				endcase
			end
			ST_BIT: if (wr_ok) state_nx = ST_PEND;
			ST_PEND: if (sts.pend_zero) state_nx = ST_RENORM;
			ST_FIN_BUMP: state_nx = ST_FIN_BIT;
			ST_FIN_BIT: if (wr_ok) state_nx = ST_FIN_PEND;
			ST_FIN_PEND: if (sts.pend_zero) state_nx = ST_FIN_PAD;
			ST_FIN_PAD: if (sts.bits_zero || room) state_nx = ST_FLUSH;
			ST_FLUSH: if (room || sts.any_byte) state_nx = ST_BAD;
			ST_BAD: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		i_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				i_ready = 1'b1;
				ctl.load = i_valid;
			end
			ST_MUL: ctl.div_start = !sts.cmd_finish && !sts.bad;
			ST_DIV: ctl.div_step = !sts.div_done;
			ST_APPLY: ctl.apply = 1'b1;
			ST_RENORM: begin
				ctl.shift_zero = (sts.ren == REN_ZERO);
				ctl.shift_one = (sts.ren == REN_ONE);
				ctl.shift_mid = (sts.ren == REN_MID);
				ctl.bump = (sts.ren == REN_MID);
			end
			ST_BIT: begin
				ctl.put_bit = wr_ok;
				ctl.out_rel = sts.byte_full && sts.out_full;
			end
			ST_PEND: begin
				ctl.put_pend = !sts.pend_zero && wr_ok;
				ctl.out_rel = !sts.pend_zero && sts.byte_full && sts.out_full;
			end
			ST_FIN_BUMP: ctl.bump = 1'b1;
			ST_FIN_BIT: begin
				ctl.put_bit = wr_ok;
				ctl.out_rel = sts.byte_full && sts.out_full;
			end
			ST_FIN_PEND: begin
				ctl.put_pend = !sts.pend_zero && wr_ok;
				ctl.out_rel = !sts.pend_zero && sts.byte_full && sts.out_full;
			end
			ST_FIN_PAD: begin
				ctl.pad = !sts.bits_zero && room;
				ctl.out_rel = !sts.bits_zero && sts.out_full;
			end
			ST_FLUSH: begin
				// held byte gets "last"; an empty run emits one marker
				ctl.out_take = sts.any_byte || room;
				ctl.clear_all = sts.cmd_finish && (room || sts.any_byte);
			end
			ST_BAD: ;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		i_ready |-> state_q == ST_IDLE)
		else $error("input taken mid-item");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && sts.bad) |=> state_q == ST_FLUSH)
		else $error("bad item not rejected");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.put_bit && ctl.put_pend) == 1'b0)
		else $error("two bits in one cycle");
endmodule
`default_nettype wire

// File: tb/tb_arithmetic_encoder_32bit.sv
// Self-checking testbench for the 32-bit arithmetic encoder: directed and random symbol streams vs. predictor.
`default_nettype none
module tb_arithmetic_encoder_32bit;
	timeunit 1ns;
	timeprecision 1ps;
	import aenc_pkg::*;

	typedef struct {
		cmd_t cmd;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] tot;
	} symbol_t;

	typedef struct {
		logic [7:0] data;
		logic bv;
		logic bad;
		logic ovf;
		logic lst;
	} coded_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic i_valid = 1'b0;
	logic i_ready;
	logic command = 1'b0;
	logic [15:0] cum_low = '0;
	logic [15:0] cum_high = '0;
	logic [15:0] total = '0;
	logic o_valid;
	logic o_ready = 1'b0;
	logic [7:0] out_byte;
	logic byte_valid;
	logic bad_input;
	logic pending_overflow;
	logic last;

	arithmetic_encoder_32bit u_top (.*);

	always #10 clk = ~clk;

	symbol_t symbol_q[$];
	coded_t coded_q[$];
	int n_symbols = 0;
	int n_accepted = 0;
	int n_errors = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;

	// encoder state mirror
	logic [31:0] iv_low = '0;
	logic [31:0] iv_high = '1;
	logic [7:0] pend = '0;
	logic [7:0] acc = '0;
	int nbits = 0;
	logic ovf_seen = 1'b0;
	logic [7:0] bytes_q[$];

	task automatic put_code_bit(input logic b);
		acc = {acc[6:0], b};
		nbits++;
		if (nbits == 8) begin
			bytes_q.insert(bytes_q.size(), acc);
			acc = '0;
			nbits = 0;
		end
	endtask

	task automatic emit_with_pend(input logic b);
		put_code_bit(b);
		while (pend != 0) begin
			put_code_bit(!b);
			pend--;
		end
	endtask

	task automatic bump_pend();
		if (pend == PendLimit) ovf_seen = 1'b1;
		else pend++;
	endtask

	task automatic encode_symbol(input symbol_t s);
		logic bad;
		logic flag;
		logic [63:0] range;
		logic [63:0] up;
		logic [63:0] dn;
		logic [7:0] padded;
		coded_t c;
		int n;
		bad = 1'b0;
		bytes_q.delete();
		if (s.cmd == CMD_ENCODE) begin
			if (s.tot == 0 || s.lo >= s.hi || s.hi > s.tot) begin
				bad = 1'b1;
			end else begin
				range = {32'd0, iv_high - iv_low} + 64'd1;
				up = (range * s.hi) / s.tot - 64'd1;
				dn = (range * s.lo) / s.tot;
				iv_high = iv_low + up[31:0];
				iv_low = iv_low + dn[31:0];
				forever begin
					if (iv_high < Half) begin
						emit_with_pend(1'b0);
					end else if (iv_low >= Half) begin
						emit_with_pend(1'b1);
						iv_low -= Half;
						iv_high -= Half;
					end else if (iv_low >= Quarter && iv_high < ThreeQ) begin
						bump_pend();
						iv_low -= Quarter;
						iv_high -= Quarter;
					end else begin
						break;
					end
					iv_low = iv_low << 1;
					iv_high = {iv_high[30:0], 1'b1};
				end
			end
			flag = ovf_seen;
		end else begin
			bump_pend();
			emit_with_pend(iv_low < Quarter ? 1'b0 : 1'b1);
			if (nbits > 0) begin
				padded = acc << (8 - nbits);
				bytes_q.insert(bytes_q.size(), padded);
			end
			flag = ovf_seen;
			iv_low = '0;
			iv_high = '1;
			pend = '0;
			acc = '0;
			nbits = 0;
			ovf_seen = 1'b0;
		end
		n = bytes_q.size() > 0 ? bytes_q.size() : 1;
		for (int k = 0; k < n; k++) begin
			c.data = bytes_q.size() > 0 ? bytes_q[k] : 8'd0;
			c.bv = bytes_q.size() > 0;
			c.bad = bad;
			c.ovf = flag;
			c.lst = (k == n - 1);
			coded_q.insert(coded_q.size(), c);
		end
	endtask

	task automatic add_sym(input cmd_t c, input int lo, input int hi, input int tot);
		symbol_t s;
		s = '{c, lo[15:0], hi[15:0], tot[15:0]};
		symbol_q.insert(symbol_q.size(), s);
	endtask

	task automatic add_good(input int mode);
		int tot;
		int hi;
		case (mode)
			0: begin
				tot = $urandom_range(1, 65535);
				hi = $urandom_range(1, tot);
				add_sym(CMD_ENCODE, $urandom_range(0, hi - 1), hi, tot);
			end
			1: begin
				// tiny share at a random spot: many output bits
				tot = $urandom_range(40000, 65535);
				hi = $urandom_range(1, tot);
				add_sym(CMD_ENCODE, hi - 1, hi, tot);
			end
			default: begin
				// narrow slice across the middle: piles up pending bits
				add_sym(CMD_ENCODE, 32767 - $urandom_range(0, 8),
					32768 + $urandom_range(1, 8), 65535);
			end
		endcase
	endtask

	task automatic add_bad();
		int tot;
		int v;
		case ($urandom_range(0, 2))
			0: add_sym(CMD_ENCODE, $urandom, $urandom, 0);
			1: begin
				tot = $urandom_range(1, 65535);
				v = $urandom_range(0, tot);
				add_sym(CMD_ENCODE, $urandom_range(v, 65535), v, tot);
			end
			default: begin
				tot = $urandom_range(0, 65534);
				v = $urandom_range(tot + 1, 65535);
				add_sym(CMD_ENCODE, $urandom_range(0, v - 1), v, tot);
			end
		endcase
	endtask

	initial begin
		int len;
		int mode;
		// directed
		add_sym(CMD_FINISH, 0, 0, 0);
		add_sym(CMD_ENCODE, 0, 65535, 65535);
		add_sym(CMD_ENCODE, 0, 1, 65535);
		add_sym(CMD_ENCODE, 65534, 65535, 65535);
		add_sym(CMD_ENCODE, 0, 1, 1);
		add_sym(CMD_ENCODE, 0, 0, 0);
		add_sym(CMD_ENCODE, 5, 5, 10);
		add_sym(CMD_ENCODE, 65535, 0, 65535);
		add_sym(CMD_ENCODE, 1, 65535, 65534);
		add_sym(CMD_ENCODE, 1, 2, 3);
		add_sym(CMD_FINISH, 65535, 65535, 65535);
		add_sym(CMD_FINISH, 0, 0, 0);
		for (int i = 0; i < 24; i++) add_good(2);
		add_sym(CMD_FINISH, 21845, 43690, 1);
		// random streams
		while (symbol_q.size() < 235) begin
			if ($urandom_range(0, 9) < 7) begin
				mode = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
				len = mode == 2 ? $urandom_range(5, 30) : $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 19) == 0) add_bad();
					else add_good(mode);
				end
				add_sym(CMD_FINISH, $urandom, $urandom, $urandom);
			end else if ($urandom_range(0, 1) == 0) begin
				add_bad();
			end else begin
				add_sym(CMD_FINISH, $urandom, $urandom, $urandom);
			end
		end
		n_symbols = symbol_q.size();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		symbol_t s;
		int idle_pct;
		if (!arst_n) begin
			i_valid <= 1'b0;
		end else begin
			if (i_valid && i_ready) begin
				encode_symbol('{cmd_t'(command), cum_low, cum_high, total});
				n_accepted++;
			end
			if (!i_valid || i_ready) begin
				idle_pct = n_accepted < n_symbols / 3 ? 22 :
					n_accepted < 2 * n_symbols / 3 ? 63 : 0;
				if (symbol_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					s = symbol_q.pop_front();
					i_valid <= 1'b1;
					command <= s.cmd;
					cum_low <= s.lo;
					cum_high <= s.hi;
					total <= s.tot;
				end else begin
					i_valid <= 1'b0;
				end
			end
		end
	end

	// receiver with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		if (!arst_n) begin
			o_ready <= 1'b0;
		end else begin
			if (!hold_done && n_accepted == 60) begin
				hold_done <= 1'b1;
				hold_cnt <= 600;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
			end
			idle_pct = n_accepted < n_symbols / 3 ? 63 :
				n_accepted < 2 * n_symbols / 3 ? 22 : 0;
			o_ready <= hold_cnt <= 1 && $urandom_range(0, 99) >= idle_pct;
		end
	end

	// checker
	always @(posedge clk) begin
		coded_t e;
		if (arst_n && o_valid && o_ready) begin
			if (coded_q.size() == 0) begin
				$display("%t: unexpected transaction byte=%h bv=%b bad=%b ovf=%b last=%b",
					$realtime, out_byte, byte_valid, bad_input, pending_overflow, last);
				n_errors++;
			end else begin
				e = coded_q.pop_front();
				if (out_byte !== e.data || byte_valid !== e.bv || bad_input !== e.bad ||
					pending_overflow !== e.ovf || last !== e.lst) begin
					$display("%t: mismatch expected byte=%h bv=%b bad=%b ovf=%b last=%b",
						$realtime, e.data, e.bv, e.bad, e.ovf, e.lst);
					$display("%t:           actual byte=%h bv=%b bad=%b ovf=%b last=%b",
						$realtime, out_byte, byte_valid, bad_input, pending_overflow, last);
					n_errors++;
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (n_symbols == 0 || n_accepted < n_symbols || coded_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (coded_q.size() == 0 && n_errors == 0) begin
			$display("tb_arithmetic_encoder_32bit passed");
		end else begin
			$display("tb_arithmetic_encoder_32bit failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("tb_arithmetic_encoder_32bit failed");
		$finish;
	end
endmodule
`default_nettype wire
